// ===== sv/ptnm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptnm_pkg
// Shared types, character codes and tone-mark tables for the pinyin tone
// number to tone mark converter.
// ----------------------------------------------------------------------------
package ptnm_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [6:0] char_t;
  typedef logic [3:0] vowel_idx_t;
  typedef logic [1:0] tone_t;
  typedef logic [8:0] code_point_t;

  // ASCII codes
  localparam byte_t ASCII_LC_A = 8'h61;
  localparam byte_t ASCII_LC_Z = 8'h7A;
  localparam byte_t ASCII_UC_A = 8'h41;
  localparam byte_t ASCII_UC_Z = 8'h5A;
  localparam byte_t ASCII_ONE  = 8'h31;
  localparam byte_t ASCII_FIVE = 8'h35;

  // Vowel table order: a A e E o O i I u U
  localparam vowel_idx_t VI_LC_A = 4'd0;
  localparam vowel_idx_t VI_UC_A = 4'd1;
  localparam vowel_idx_t VI_LC_E = 4'd2;
  localparam vowel_idx_t VI_UC_E = 4'd3;
  localparam vowel_idx_t VI_LC_O = 4'd4;
  localparam vowel_idx_t VI_UC_O = 4'd5;
  localparam vowel_idx_t VI_LC_I = 4'd6;
  localparam vowel_idx_t VI_UC_I = 4'd7;
  localparam vowel_idx_t VI_LC_U = 4'd8;
  localparam vowel_idx_t VI_UC_U = 4'd9;

  // Number of vowel classes tracked by first position (a A e E o O)
  localparam int NumFirstCls = 6;

  typedef struct packed {
    logic       hit;
    vowel_idx_t idx;
  } vowel_hit_t;

  // Classify a 7-bit letter as one of the ten vowels
  function automatic vowel_hit_t vowel_lookup(input char_t c);
    vowel_hit_t r;
    r.hit = 1'b1;
    case (c)
      7'h61:   r.idx = VI_LC_A;
      7'h41:   r.idx = VI_UC_A;
      7'h65:   r.idx = VI_LC_E;
      7'h45:   r.idx = VI_UC_E;
      7'h6F:   r.idx = VI_LC_O;
      7'h4F:   r.idx = VI_UC_O;
      7'h69:   r.idx = VI_LC_I;
      7'h49:   r.idx = VI_UC_I;
      7'h75:   r.idx = VI_LC_U;
      7'h55:   r.idx = VI_UC_U;
      default: begin
        r.hit = 1'b0;
        r.idx = VI_LC_A;
      end
    endcase
    return r;
  endfunction

  // Code point of a toned vowel; tones 1..4 map to 0..3
  function automatic code_point_t toned_cp(input vowel_idx_t vi, input tone_t tone);
    logic [35:0] row;
    case (vi)
      VI_LC_A: row = {9'h0E0, 9'h1CE, 9'h0E1, 9'h101};
      VI_UC_A: row = {9'h0C0, 9'h1CD, 9'h0C1, 9'h100};
      VI_LC_E: row = {9'h0E8, 9'h11B, 9'h0E9, 9'h113};
      VI_UC_E: row = {9'h0C8, 9'h11A, 9'h0C9, 9'h112};
      VI_LC_O: row = {9'h0F2, 9'h1D2, 9'h0F3, 9'h14D};
      VI_UC_O: row = {9'h0D2, 9'h1D1, 9'h0D3, 9'h14C};
      VI_LC_I: row = {9'h0EC, 9'h1D0, 9'h0ED, 9'h12B};
      VI_UC_I: row = {9'h0CC, 9'h1CF, 9'h0CD, 9'h12A};
      VI_LC_U: row = {9'h0F9, 9'h1D4, 9'h0FA, 9'h16B};
      VI_UC_U: row = {9'h0D9, 9'h1D3, 9'h0DA, 9'h16A};
      default: row = '0;
    endcase
    return row[tone*9 +: 9];
  endfunction

endpackage

// ===== sv/ptnm_in_if.sv =====
// ----------------------------------------------------------------------------
// ptnm_in_if
// Valid/ready channel carrying one byte of numbered pinyin text.
// ----------------------------------------------------------------------------
interface ptnm_in_if;
  import ptnm_pkg::*;

  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== sv/ptnm_out_if.sv =====
// ----------------------------------------------------------------------------
// ptnm_out_if
// Valid/ready channel carrying one byte of converted, tone-marked output.
// ----------------------------------------------------------------------------
interface ptnm_out_if;
  import ptnm_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  last_of_syllable;
  logic  dropped;

  modport source (output valid, output out_byte, output last_of_syllable,
                  output dropped, input ready);
  modport sink   (input valid, input out_byte, input last_of_syllable,
                  input dropped, output ready);
endinterface

// ===== sv/pinyin_tone_number_to_mark_core.sv =====
// ----------------------------------------------------------------------------
// pinyin_tone_number_to_mark_core
// Converts numbered pinyin (e.g. "hao3") into UTF-8 tone-marked pinyin.
//
//   channel  dir  payload                               transfer when
//   in_i     in   in_byte[7:0]                          valid & ready
//   out_o    out  out_byte[7:0], last_of_syllable,      valid & ready
//                 dropped
//
// Letters and non-tone bytes are taken while idle. A tone digit starts the
// emission of one output byte per letter (plus one extra for the marked
// vowel), paced by the one-letter-per-cycle read of the letter RAM and the
// single output register, and held while out_o stalls. A dropped syllable
// gives one zero byte. Output stalls hold the emitter; in_i is ready only
// while it is idle. No clearing pass after reset: the letter RAM is only
// read below the fill count.
// ----------------------------------------------------------------------------
module pinyin_tone_number_to_mark_core #(
  parameter int MAX_LETTERS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ptnm_in_if.sink           in_i,
  ptnm_out_if.source        out_o
);
  import ptnm_pkg::*;

  localparam int AddrW = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
  localparam int LenW  = $clog2(MAX_LETTERS + 1);

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [LenW-1:0]  len_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EMIT   = 4'b0010,
    S_SECOND = 4'b0100,
    S_DROP   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Run tracking
  len_t       len_q, len_d;
  logic       ovf_q, ovf_d;
  logic [NumFirstCls-1:0] cls_found_q, cls_found_d;
  addr_t      cls_pos_q [NumFirstCls];
  addr_t      cls_pos_d [NumFirstCls];
  logic       has_u_q, has_u_d;
  logic       lastv_found_q, lastv_found_d;
  addr_t      lastv_pos_q, lastv_pos_d;
  vowel_idx_t lastv_vi_q, lastv_vi_d;

  // Emission context
  addr_t       idx_q, idx_d;
  addr_t       last_idx_q, last_idx_d;
  logic        mark_en_q, mark_en_d;
  addr_t       mark_pos_q, mark_pos_d;
  code_point_t cp_q, cp_d;

  // Output register
  logic  out_valid_q, out_valid_d;
  byte_t out_byte_q, out_byte_d;
  logic  out_last_q, out_last_d;
  logic  out_drop_q, out_drop_d;

  // Letter RAM
  char_t mem [MAX_LETTERS];
  char_t rd_q;
  logic  wr_en;
  logic  rd_en;
  addr_t rd_addr;

  // Decode of the incoming byte
  logic       in_xfer;
  logic       is_letter;
  logic       is_tone;
  vowel_hit_t in_vowel;
  logic       sel_found;
  addr_t      sel_pos;
  vowel_idx_t sel_vi;
  logic       out_free;
  logic       at_mark;
  logic       at_last;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign is_letter = (in_i.in_byte >= ASCII_LC_A && in_i.in_byte <= ASCII_LC_Z) ||
                     (in_i.in_byte >= ASCII_UC_A && in_i.in_byte <= ASCII_UC_Z);
  assign is_tone   = (in_i.in_byte >= ASCII_ONE && in_i.in_byte <= ASCII_FIVE);
  assign in_vowel  = vowel_lookup(in_i.in_byte[6:0]);
  assign out_free  = !out_valid_q || out_o.ready;
  assign at_mark   = mark_en_q && (idx_q == mark_pos_q);
  assign at_last   = (idx_q == last_idx_q);

  assign in_i.ready             = (state_q == S_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.out_byte         = out_byte_q;
  assign out_o.last_of_syllable = out_last_q;
  assign out_o.dropped          = out_drop_q;

  // Vowel choice: first a, A, e, E; then o, O if the run has a u; else last
  always_comb begin
    sel_found = lastv_found_q;
    sel_pos   = lastv_pos_q;
    sel_vi    = lastv_vi_q;
    for (int k = NumFirstCls - 1; k >= 0; k--) begin
      if (cls_found_q[k] && (k < 4 || has_u_q)) begin
        sel_found = 1'b1;
        sel_pos   = cls_pos_q[k];
        sel_vi    = vowel_idx_t'(k);
      end
    end
  end

  // Main control
  always_comb begin
    state_d       = state_q;
    len_d         = len_q;
    ovf_d         = ovf_q;
    cls_found_d   = cls_found_q;
    cls_pos_d     = cls_pos_q;
    has_u_d       = has_u_q;
    lastv_found_d = lastv_found_q;
    lastv_pos_d   = lastv_pos_q;
    lastv_vi_d    = lastv_vi_q;
    idx_d         = idx_q;
    last_idx_d    = last_idx_q;
    mark_en_d     = mark_en_q;
    mark_pos_d    = mark_pos_q;
    cp_d          = cp_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_byte_d    = out_byte_q;
    out_last_d    = out_last_q;
    out_drop_d    = out_drop_q;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = idx_q + addr_t'(1);

    case (state_q)
      S_IDLE: begin
        rd_addr = '0;
        if (in_xfer) begin
          if (is_letter) begin
            if (len_q < len_t'(MAX_LETTERS)) begin
              wr_en = 1'b1;
              len_d = len_q + len_t'(1);
              if (in_vowel.hit) begin
                lastv_found_d = 1'b1;
                lastv_pos_d   = len_q[AddrW-1:0];
                lastv_vi_d    = in_vowel.idx;
                if (in_vowel.idx == VI_LC_U || in_vowel.idx == VI_UC_U) begin
                  has_u_d = 1'b1;
                end
                for (int k = 0; k < NumFirstCls; k++) begin
                  if (in_vowel.idx == vowel_idx_t'(k) && !cls_found_q[k]) begin
                    cls_found_d[k] = 1'b1;
                    cls_pos_d[k]   = len_q[AddrW-1:0];
                  end
                end
              end
            end else begin
              ovf_d = 1'b1;
            end
          end else if (!is_tone || ovf_q || len_q != '0) begin
            // Any syllable end or separator clears the run
            len_d         = '0;
            ovf_d         = 1'b0;
            cls_found_d   = '0;
            has_u_d       = 1'b0;
            lastv_found_d = 1'b0;
            if (is_tone && ovf_q) begin
              state_d = S_DROP;
            end else if (is_tone) begin
              mark_en_d  = sel_found && (in_i.in_byte != ASCII_FIVE);
              mark_pos_d = sel_pos;
              cp_d       = toned_cp(sel_vi, tone_t'(in_i.in_byte[2:0] - 3'd1));
              last_idx_d = addr_t'(len_q - len_t'(1));
              idx_d      = '0;
              rd_en      = 1'b1;
              state_d    = S_EMIT;
            end
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_drop_d  = 1'b0;
          if (at_mark) begin
            out_byte_d = {3'b110, 2'b00, cp_q[8:6]};
            out_last_d = 1'b0;
            state_d    = S_SECOND;
          end else begin
            out_byte_d = {1'b0, rd_q};
            out_last_d = at_last;
            if (at_last) begin
              state_d = S_IDLE;
            end else begin
              idx_d = idx_q + addr_t'(1);
              rd_en = 1'b1;
            end
          end
        end
      end

      S_SECOND: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_drop_d  = 1'b0;
          out_byte_d  = {2'b10, cp_q[5:0]};
          out_last_d  = at_last;
          if (at_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + addr_t'(1);
            rd_en   = 1'b1;
            state_d = S_EMIT;
          end
        end
      end

      S_DROP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = '0;
          out_last_d  = 1'b1;
          out_drop_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Letter RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[len_q[AddrW-1:0]] <= in_i.in_byte[6:0];
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      len_q         <= '0;
      ovf_q         <= 1'b0;
      cls_found_q   <= '0;
      has_u_q       <= 1'b0;
      lastv_found_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      len_q         <= len_d;
      ovf_q         <= ovf_d;
      cls_found_q   <= cls_found_d;
      has_u_q       <= has_u_d;
      lastv_found_q <= lastv_found_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cls_pos_q   <= cls_pos_d;
    lastv_pos_q <= lastv_pos_d;
    lastv_vi_q  <= lastv_vi_d;
    idx_q       <= idx_d;
    last_idx_q  <= last_idx_d;
    mark_en_q   <= mark_en_d;
    mark_pos_q  <= mark_pos_d;
    cp_q        <= cp_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_drop_q  <= out_drop_d;
  end

  // Checks
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= len_t'(MAX_LETTERS))
    else $error("letter count beyond buffer depth");

  a_drop_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_drop_q |-> out_last_q && (out_byte_q == '0))
    else $error("dropped transfer not a lone zero byte");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) && (state_d == S_IDLE) |=> out_valid_q && out_last_q)
    else $error("syllable ended without a last byte");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT || state_q == S_SECOND) |-> !in_xfer && !wr_en)
    else $error("input taken while emitting");

endmodule

// ===== dv/pinyin_tone_number_to_mark_core_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pinyin_tone_number_to_mark_core_checker
// Watches both channels of the pinyin converter, rebuilds the letter run from
// every accepted input byte, predicts the UTF-8 syllable bytes a tone digit
// must produce, and compares each output transfer field by field against the
// oldest predicted byte. Mismatch count and outstanding byte count go to the
// test top.
// ----------------------------------------------------------------------------
module pinyin_tone_number_to_mark_core_checker #(
  parameter int MAX_LETTERS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  ptnm_pkg::byte_t in_byte_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  ptnm_pkg::byte_t out_byte_i,
  input  logic            out_last_i,
  input  logic            out_dropped_i,
  output int              error_count_o,
  output int              pending_o
);
  import ptnm_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  last;
    logic  dropped;
  } syllable_byte_t;

  localparam int NEUTRAL_TONE = 4;

  // Vowels in marking-table order: a A e E o O i I u U
  localparam char_t VOWEL_CHARS [10] = '{
    7'h61, 7'h41, 7'h65, 7'h45, 7'h6F, 7'h4F, 7'h69, 7'h49, 7'h75, 7'h55
  };

  // Toned code points, tones 1 to 4
  localparam logic [8:0] MARKED_CP [10][4] = '{
    '{9'h101, 9'h0E1, 9'h1CE, 9'h0E0},
    '{9'h100, 9'h0C1, 9'h1CD, 9'h0C0},
    '{9'h113, 9'h0E9, 9'h11B, 9'h0E8},
    '{9'h112, 9'h0C9, 9'h11A, 9'h0C8},
    '{9'h14D, 9'h0F3, 9'h1D2, 9'h0F2},
    '{9'h14C, 9'h0D3, 9'h1D1, 9'h0D2},
    '{9'h12B, 9'h0ED, 9'h1D0, 9'h0EC},
    '{9'h12A, 9'h0CD, 9'h1CF, 9'h0CC},
    '{9'h16B, 9'h0FA, 9'h1D4, 9'h0F9},
    '{9'h16A, 9'h0DA, 9'h1D3, 9'h0D9}
  };

  // Mirror of the letter run held by the block
  char_t          held_letters [MAX_LETTERS];
  int unsigned    held_cnt;
  logic           held_overflow;
  syllable_byte_t syllable_q [$];
  int             mismatches;

  assign error_count_o = mismatches;

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $time);
    mismatches++;
  endtask

  function automatic int vowel_slot(input char_t c);
    int slot;
    slot = -1;
    for (int i = 9; i >= 0; i--)
      if (VOWEL_CHARS[i] == c) slot = i;
    return slot;
  endfunction

  function automatic int first_pos(input vowel_idx_t slot);
    int pos;
    pos = -1;
    for (int i = int'(held_cnt) - 1; i >= 0; i--)
      if (held_letters[i] == VOWEL_CHARS[slot]) pos = i;
    return pos;
  endfunction

  // a, A, e, E; o or O only when the run holds u or U; else last vowel
  function automatic int mark_position();
    int pos;
    pos = first_pos(VI_LC_A);
    if (pos < 0) pos = first_pos(VI_UC_A);
    if (pos < 0) pos = first_pos(VI_LC_E);
    if (pos < 0) pos = first_pos(VI_UC_E);
    if (pos < 0 && (first_pos(VI_LC_U) >= 0 || first_pos(VI_UC_U) >= 0)) begin
      pos = first_pos(VI_LC_O);
      if (pos < 0) pos = first_pos(VI_UC_O);
    end
    if (pos < 0)
      for (int i = 0; i < int'(held_cnt); i++)
        if (vowel_slot(held_letters[i]) >= 0) pos = i;
    return pos;
  endfunction

  // Update the run for one input byte and queue the bytes it produces
  function automatic void convert_byte(input byte_t c);
    int         tone;
    int         pos;
    int         slot;
    logic       last;
    logic [8:0] cp;
    if ((c >= ASCII_LC_A && c <= ASCII_LC_Z) || (c >= ASCII_UC_A && c <= ASCII_UC_Z)) begin
      if (held_cnt < MAX_LETTERS) begin
        held_letters[held_cnt] = c[6:0];
        held_cnt++;
      end else begin
        held_overflow = 1'b1;
      end
    end else if (c < ASCII_ONE || c > ASCII_FIVE) begin
      held_cnt      = 0;
      held_overflow = 1'b0;
    end else if (held_overflow) begin
      syllable_q.push_back('{data: 8'h00, last: 1'b1, dropped: 1'b1});
      held_cnt      = 0;
      held_overflow = 1'b0;
    end else if (held_cnt != 0) begin
      tone = int'(c - ASCII_ONE);
      pos  = (tone == NEUTRAL_TONE) ? -1 : mark_position();
      for (int i = 0; i < int'(held_cnt); i++) begin
        last = (i == int'(held_cnt) - 1);
        slot = (i == pos) ? vowel_slot(held_letters[i]) : -1;
        if (slot >= 0) begin
          cp = MARKED_CP[slot][tone];
          syllable_q.push_back('{data: {3'b110, 2'b00, cp[8:6]}, last: 1'b0, dropped: 1'b0});
          syllable_q.push_back('{data: {2'b10, cp[5:0]}, last: last, dropped: 1'b0});
        end else begin
          syllable_q.push_back('{data: {1'b0, held_letters[i]}, last: last, dropped: 1'b0});
        end
      end
      held_cnt      = 0;
      held_overflow = 1'b0;
    end
  endfunction

  // Compare outputs first, then predict from the input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    syllable_byte_t oldest;
    if (!rst_ni) begin
      syllable_q.delete();
      held_cnt      = 0;
      held_overflow = 1'b0;
      mismatches    = 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (syllable_q.size() == 0) begin
          report_mismatch("unexpected byte", int'(out_byte_i), 0);
        end else begin
          oldest = syllable_q.pop_front();
          if (out_byte_i !== oldest.data)
            report_mismatch("out_byte", int'(out_byte_i), int'(oldest.data));
          if (out_last_i !== oldest.last)
            report_mismatch("last_of_syllable", int'(out_last_i), int'(oldest.last));
          if (out_dropped_i !== oldest.dropped)
            report_mismatch("dropped", int'(out_dropped_i), int'(oldest.dropped));
        end
      end
      if (in_valid_i && in_ready_i) convert_byte(in_byte_i);
      pending_o <= syllable_q.size();
    end
  end

endmodule

// ===== dv/pinyin_tone_number_to_mark_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pinyin_tone_number_to_mark_core_test
// Feeds numbered pinyin text into the converter: a directed opener for the
// vowel choice rules, neutral tone, overflow and stray bytes, then random
// syllables mixed with noise, with random stalls on both channels. The
// checker predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module pinyin_tone_number_to_mark_core_test;
  import ptnm_pkg::*;

  localparam int    MAX_LETTERS  = 8;
  localparam int    RANDOM_BYTES = 340;
  localparam int    STALL_LIMIT  = 200;
  localparam int    DRAIN_CYCLES = 16;
  localparam string VOWEL_TEXT   = "aeiouAEIOU";

  logic clk_i;
  logic rst_ni;
  int   idle_pct;
  int   sent;
  int   errors;
  int   pending;
  int   quiet_cycles;

  ptnm_in_if  in_ch ();
  ptnm_out_if out_ch ();

  pinyin_tone_number_to_mark_core #(
    .MAX_LETTERS (MAX_LETTERS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  pinyin_tone_number_to_mark_core_checker #(
    .MAX_LETTERS (MAX_LETTERS)
  ) checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_ch.valid),
    .in_ready_i    (in_ch.ready),
    .in_byte_i     (in_ch.in_byte),
    .out_valid_i   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .out_byte_i    (out_ch.out_byte),
    .out_last_i    (out_ch.last_of_syllable),
    .out_dropped_i (out_ch.dropped),
    .error_count_o (errors),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Ends the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output side back-pressure in bursts
  initial begin : sink_pacing
    int unsigned hold;
    out_ch.ready = 1'b0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(99) < idle_pct) begin
        hold = $urandom_range(9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // One input transfer, followed now and then by an idle burst
  task automatic send_byte(input byte_t b);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(byte_t'(s[i]));
  endtask

  // Half vowels so the marking rules get exercised
  function automatic byte_t random_letter();
    if ($urandom_range(1))
      return byte_t'(VOWEL_TEXT[$urandom_range(9)]);
    else if ($urandom_range(1))
      return byte_t'(ASCII_LC_A + $urandom_range(25));
    else
      return byte_t'(ASCII_UC_A + $urandom_range(25));
  endfunction

  // Letter run ended by a tone digit; now and then too long for the buffer
  task automatic send_syllable();
    int unsigned len;
    len = ($urandom_range(9) == 0) ? $urandom_range(MAX_LETTERS + 3, MAX_LETTERS + 1)
                                   : $urandom_range(MAX_LETTERS, 1);
    repeat (len) send_byte(random_letter());
    send_byte(byte_t'(ASCII_ONE + $urandom_range(4)));
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    int  base;
    int  unit;
    bit  paused;
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    idle_pct      = 25;
    sent          = 0;
    paused        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opener
    send_text("guo2");        // u present: o takes the mark
    send_text("xyz1");        // no vowel: sent unmarked
    send_byte(8'hFF);         // high byte clears the run
    send_text("3");           // tone digit with an empty run
    send_text("abcdefghi4");  // ninth letter overflows: dropped syllable
    send_text("n");
    send_byte(8'h00);         // zero byte clears the run
    send_text("Ou3");         // uppercase O with u
    send_text("hA5");         // neutral tone: unmarked

    // Random syllables, broken runs and noise
    base = sent;
    while (sent < base + RANDOM_BYTES) begin
      if (sent >= base + 300) begin
        idle_pct = 0;
      end else if (sent >= base + 200) begin
        idle_pct = 45;
        if (!paused) begin
          paused = 1'b1;
          wait_for_drain();
        end
      end else if (sent >= base + 120) begin
        idle_pct = 0;
      end else begin
        idle_pct = 25;
      end
      unit = $urandom_range(99);
      if (unit < 72) begin
        send_syllable();
      end else if (unit < 84) begin
        repeat ($urandom_range(4, 1)) send_byte(random_letter());
        send_byte(byte_t'($urandom_range(255)));
      end else begin
        send_byte(byte_t'($urandom_range(255)));
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ptnm_pkg.sv
sv/ptnm_in_if.sv
sv/ptnm_out_if.sv
sv/pinyin_tone_number_to_mark_core.sv
dv/pinyin_tone_number_to_mark_core_checker.sv
dv/pinyin_tone_number_to_mark_core_test.sv
